### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the stream reduction checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with a reset qualifier.
`define SRD_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the checker's own clock and reset.
`define SRD_ASSERT(lbl, prop, msg) \
    `SRD_ASSERT_ON(lbl, i_clk, i_rst_n, prop, msg)

`endif

### design/srd_pkg.sv
// ---------------------------------------------------------------------------
// srd_pkg
// Constants, codes and types of the stream reduction unit.
// ---------------------------------------------------------------------------
package srd_pkg;

    localparam int MAX_RUN   = 65536;
    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = 17;
    localparam int VAL_W     = 32;
    localparam int RES_W     = 64;
    localparam int DVD_W     = 128 + FRAC_BITS;
    localparam int DVS_W     = 34;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 3;

    localparam logic [CNT_W-1:0] MAX_RUN_CNT = CNT_W'(MAX_RUN);
    localparam logic [RES_W-1:0] POS_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

    // op_mode codes
    localparam logic [2:0] OP_SUM  = 3'd0;
    localparam logic [2:0] OP_PROD = 3'd1;
    localparam logic [2:0] OP_MAX  = 3'd2;
    localparam logic [2:0] OP_MIN  = 3'd3;
    localparam logic [2:0] OP_MEAN = 3'd4;
    localparam logic [2:0] OP_VAR  = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTE = 2'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### design/srd_in_if.sv
// ---------------------------------------------------------------------------
// srd_in_if
// Element request channel: valid/ready with value and last flag.
// ---------------------------------------------------------------------------
interface srd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

### design/srd_out_if.sv
// ---------------------------------------------------------------------------
// srd_out_if
// Result request channel: valid/ready with result, saturation and length.
// ---------------------------------------------------------------------------
interface srd_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] result;
    logic               saturated;
    logic [16:0]        run_length;

    modport source (output valid, output result, output saturated, output run_length,
                    input ready);
    modport sink   (input valid, input result, input saturated, input run_length,
                    output ready);
endinterface

### design/srd_div.sv
// ---------------------------------------------------------------------------
// srd_div
// Restoring bit-serial divider, one quotient bit per cycle, with overflow
// detection for quotients of 2^63 and above.
// ---------------------------------------------------------------------------
module srd_div import srd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [62:0]      o_quot,
    output logic             o_ovf
);

    logic [DVD_W-1:0]     r_dvd;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVS_W-1:0]     r_rem;
    logic [63:0]          r_quo;
    logic                 r_ovf;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] n_rem;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};
    assign n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
            // a bit shifted out of the top means the quotient reached 2^63
            r_ovf <= r_ovf | r_quo[63];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo[62:0];
    assign o_ovf       = r_ovf | r_quo[63];

endmodule

### design/stream_reduction_unit.sv
// ---------------------------------------------------------------------------
// stream_reduction_unit
// Reduces runs of integer elements to sum, product, max, min, mean or
// population variance using one shared 32x32 multiplier and a serial divider.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries elements (value, last); a run closes on last or when it
//   reaches MAX_RUN elements. o_out carries one result per run.
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes op_mode
//   (index 0) or elem_unsigned_byte (index 1); any valid write drops the
//   current run. Write only while the block is idle.
// Sequence:
//   Each element passes the shared multiplier in the steps square, accumulate,
//   product (product mode only) and close check before the next one is taken.
//   Closing a run adds an output step for sum/product/max/min, a divide for
//   mean (one divider bit per cycle over 128+FRAC_BITS bits) and, for variance,
//   multiply-accumulate steps on the shared multiplier, then the divide.
// Reset and stall:
//   Synchronous active-low reset clears the state, the config registers,
//   the run and the output valid. The result sits in an output register;
//   while the receiver stalls, the block still takes elements of the next
//   run and holds only when a second result is ready to leave.
// ---------------------------------------------------------------------------
module stream_reduction_unit import srd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    srd_in_if.sink               i_in,
    srd_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EMUL  = 4'd1;
    localparam logic [3:0] S_EACC  = 4'd2;
    localparam logic [3:0] S_EPROD = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_FMUL  = 4'd5;
    localparam logic [3:0] S_FACC  = 4'd6;
    localparam logic [3:0] S_DSTRT = 4'd7;
    localparam logic [3:0] S_DWAIT = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam logic [3:0] STEP_NN = 4'd8;

    logic [3:0]        r_state;
    logic [2:0]        r_op_mode;
    logic              r_byte;
    logic [CNT_W-1:0]  r_cnt;
    logic [63:0]       r_rv;
    logic [127:0]      r_sq_sum;
    logic [63:0]       r_v;
    logic [31:0]       r_mag;
    logic              r_last;
    logic              r_close;
    logic [63:0]       r_mul;
    logic [127:0]      r_acc;
    logic [3:0]        r_step;
    logic [DVD_W-1:0]  r_dvd_in;
    logic [DVS_W-1:0]  r_dvs_in;
    logic              r_ovalid;
    logic [63:0]       r_res;
    logic              r_sat;
    logic [CNT_W-1:0]  r_len;

    logic              cfg_hit;
    logic              in_fire;
    logic              out_free;
    logic              out_load;
    logic [63:0]       in_v;
    logic [31:0]       in_mag;
    logic [CNT_W-1:0]  n_cnt;
    logic              sneg;
    logic [63:0]       smag;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic              mul_en;
    logic [127:0]      mul_sh;
    logic [63:0]       mean_m;
    logic [63:0]       n_res;
    t_div_stat         div_stat;
    logic [62:0]       div_quot;
    logic              div_ovf;

    assign cfg_hit  = i_cfg_we && (i_cfg_idx == CFG_OP_MODE || i_cfg_idx == CFG_ELEM_BYTE);
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign out_load = (r_state == S_OUT) && out_free && !cfg_hit;

    assign in_v   = r_byte ? {56'd0, i_in.value[7:0]} : {{32{i_in.value[31]}}, i_in.value};
    assign in_mag = r_byte ? {24'd0, i_in.value[7:0]}
                  : (i_in.value[31] ? (~i_in.value + 32'd1) : i_in.value);
    assign n_cnt  = r_cnt + CNT_W'(1);

    assign sneg = r_rv[63];
    assign smag = sneg ? (~r_rv + 64'd1) : r_rv;

    // shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        unique case (r_state)
            S_EMUL: begin
                mul_a  = r_mag;
                mul_b  = r_mag;
                mul_en = 1'b1;
            end
            S_EACC: begin
                mul_a  = r_rv[31:0];
                mul_b  = r_v[31:0];
                mul_en = 1'b1;
            end
            S_FMUL: begin
                mul_en = 1'b1;
                priority if (r_step < 4'd4) begin
                    mul_a = 32'(r_cnt);
                    mul_b = r_sq_sum[32*r_step[1:0] +: 32];
                end else if (r_step == 4'd4) begin
                    mul_a = smag[31:0];
                    mul_b = smag[31:0];
                end else if (r_step == 4'd5) begin
                    mul_a = smag[31:0];
                    mul_b = smag[63:32];
                end else if (r_step == 4'd6) begin
                    mul_a = smag[63:32];
                    mul_b = smag[31:0];
                end else if (r_step == 4'd7) begin
                    mul_a = smag[63:32];
                    mul_b = smag[63:32];
                end else begin
                    mul_a = 32'(r_cnt);
                    mul_b = 32'(r_cnt);
                end
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // align the partial product for the accumulator
    always_comb begin
        priority if (r_step < 4'd4) begin
            mul_sh = {64'd0, r_mul} << (7'd32 * 7'(r_step[1:0]));
        end else if (r_step == 4'd4) begin
            mul_sh = {64'd0, r_mul};
        end else if (r_step == 4'd7) begin
            mul_sh = {r_mul, 64'd0};
        end else begin
            mul_sh = {32'd0, r_mul, 32'd0};
        end
    end

    assign mean_m = div_ovf ? POS_MAX : {1'b0, div_quot};

    always_comb begin
        unique case (r_op_mode)
            OP_SUM, OP_PROD, OP_MAX, OP_MIN:
                n_res = r_byte ? {56'd0, r_rv[7:0]} : {{32{r_rv[31]}}, r_rv[31:0]};
            default:
                n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_mul <= mul_a * mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op_mode <= OP_SUM;
            r_byte    <= 1'b0;
            r_cnt     <= '0;
            r_rv      <= '0;
            r_sq_sum  <= '0;
            r_ovalid  <= 1'b0;
            r_step    <= '0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_hit) begin
                // drop the current run
                if (i_cfg_idx == CFG_OP_MODE) begin
                    r_op_mode <= i_cfg_data;
                end else begin
                    r_byte <= i_cfg_data[0];
                end
                r_cnt    <= '0;
                r_rv     <= '0;
                r_sq_sum <= '0;
                r_state  <= S_IDLE;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (in_fire) begin
                            r_v     <= in_v;
                            r_mag   <= in_mag;
                            r_last  <= i_in.last;
                            r_state <= S_EMUL;
                        end
                    end
                    S_EMUL: begin
                        r_state <= S_EACC;
                    end
                    S_EACC: begin
                        r_sq_sum <= r_sq_sum + {64'd0, r_mul};
                        r_cnt    <= n_cnt;
                        r_close  <= r_last || (n_cnt == MAX_RUN_CNT);
                        r_state  <= S_CHK;
                        unique case (r_op_mode)
                            OP_PROD: begin
                                if (r_cnt == '0) begin
                                    r_rv <= r_v;
                                end else begin
                                    r_state <= S_EPROD;
                                end
                            end
                            OP_MAX: begin
                                if (r_cnt == '0 || $signed(r_v) > $signed(r_rv)) begin
                                    r_rv <= r_v;
                                end
                            end
                            OP_MIN: begin
                                if (r_cnt == '0 || $signed(r_v) < $signed(r_rv)) begin
                                    r_rv <= r_v;
                                end
                            end
                            default: begin
                                r_rv <= r_rv + r_v;
                            end
                        endcase
                    end
                    S_EPROD: begin
                        r_rv    <= r_mul;
                        r_state <= S_CHK;
                    end
                    S_CHK: begin
                        if (!r_close) begin
                            r_state <= S_IDLE;
                        end else if (r_op_mode == OP_MEAN) begin
                            r_dvd_in <= DVD_W'({64'd0, smag}) << FRAC_BITS;
                            r_dvs_in <= DVS_W'(r_cnt);
                            r_state  <= S_DSTRT;
                        end else if (r_op_mode == OP_VAR) begin
                            r_acc   <= '0;
                            r_step  <= '0;
                            r_state <= S_FMUL;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                    S_FMUL: begin
                        r_state <= S_FACC;
                    end
                    S_FACC: begin
                        if (r_step == STEP_NN) begin
                            r_dvs_in <= r_mul[DVS_W-1:0];
                            r_dvd_in <= DVD_W'(r_acc) << FRAC_BITS;
                            r_state  <= S_DSTRT;
                        end else begin
                            // add n*S2 terms, subtract S1^2 terms
                            r_acc   <= (r_step < 4'd4) ? (r_acc + mul_sh) : (r_acc - mul_sh);
                            r_step  <= r_step + 4'd1;
                            r_state <= S_FMUL;
                        end
                    end
                    S_DSTRT: begin
                        r_state <= S_DWAIT;
                    end
                    S_DWAIT: begin
                        if (div_stat.done) begin
                            r_state <= S_OUT;
                        end
                    end
                    S_OUT: begin
                        // load the output register only once the previous request left
                        if (out_free) begin
                            if (r_op_mode == OP_MEAN || r_op_mode == OP_VAR) begin
                                r_res <= (r_op_mode == OP_MEAN && sneg) ? (~mean_m + 64'd1)
                                                                         : mean_m;
                                r_sat <= div_ovf;
                            end else begin
                                r_res <= n_res;
                                r_sat <= 1'b0;
                            end
                            r_len    <= r_cnt;
                            r_cnt    <= '0;
                            r_rv     <= '0;
                            r_sq_sum <= '0;
                            r_state  <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    srd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTRT),
        .i_dividend (r_dvd_in),
        .i_divisor  (r_dvs_in),
        .o_stat     (div_stat),
        .o_quot     (div_quot),
        .o_ovf      (div_ovf)
    );

    assign o_out.valid      = r_ovalid;
    assign o_out.result     = r_res;
    assign o_out.saturated  = r_sat;
    assign o_out.run_length = r_len;

endmodule

### design/srd_checker.sv
// ---------------------------------------------------------------------------
// srd_checker
// Port-level checks on the result channel of the stream reduction unit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module srd_checker import srd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_result,
    input logic        i_out_sat,
    input logic [16:0] i_out_len
);

    // hold a stalled request
    `SRD_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result request dropped while stalled")
    `SRD_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_result), "stalled result changed")
    // a clipped result is the largest magnitude
    `SRD_ASSERT(a_sat_clip, i_out_valid && i_out_sat |-> i_out_result == POS_MAX || i_out_result == (~POS_MAX + 64'd1), "saturated result not at full scale")
    `SRD_ASSERT(a_len_range, i_out_valid |-> i_out_len != '0 && i_out_len <= MAX_RUN_CNT, "run length out of range")

endmodule

bind stream_reduction_unit srd_checker u_srd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.result),
    .i_out_sat    (o_out.saturated),
    .i_out_len    (o_out.run_length)
);
